// ===== rtl/psa_pkg.sv =====
// Package for the paged segment allocator.
// Holds the segment tag layout, status codes and fixed field widths.
// No dependencies.
package psa_pkg;

    // Segment run tag: in-use bit and 7-bit run length
    typedef struct packed {
        logic       used;
        logic [6:0] len;
    } t_tag;

    typedef logic [2:0] t_status;

    localparam t_status STAT_OK        = 3'd0;
    localparam t_status STAT_ZERO_SIZE = 3'd1;
    localparam t_status STAT_NO_MEM    = 3'd2;
    localparam t_status STAT_NULL_FREE = 3'd3;
    localparam t_status STAT_DBL_FREE  = 3'd4;
    localparam t_status STAT_NOT_ALLOC = 3'd5;

    // Field widths
    localparam int BYTES_W = 16;
    localparam int OWNER_W = 16;
    localparam int OFF_W   = 18;
    // Segment index counter, holds index plus one run length
    localparam int SEGC_W  = 8;
    // Need saturates at 129, above any 7-bit run length
    localparam int NEED_MAX = 129;
    // Page table entry: claimed bit over owner
    localparam int PTE_W   = OWNER_W + 1;

endpackage

// ===== rtl/psa_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with a registered read port.
// Used for the page owner table and the segment tag store. No dependencies.
module psa_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [W-1:0]  o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [W-1:0]  i_wr_data
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_q;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

// ===== rtl/paged_segment_allocator_core.sv =====
// Paged segment allocator: sequencer around a page owner RAM and a segment tag RAM.
// Allocate turns the byte size into segments, then reads the owner entry of each page
// visited and the tag of each run walked; free finds the page, walks the runs and merges
// with free neighbours. One request at a time.
// Reset: synchronous, active low; afterwards a clearing pass rewrites every tag entry
// and every page entry, during which requests are stalled.
module paged_segment_allocator_core #(
    parameter int PAGES      = 64,
    parameter int SEGMENTS   = 124,
    parameter int SEG_BYTES  = 32,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_kind,
    input  logic [psa_pkg::BYTES_W-1:0] i_request_bytes,
    input  logic [psa_pkg::OWNER_W-1:0] i_owner_id,
    input  logic [psa_pkg::OFF_W-1:0]   i_free_offset,
    input  logic                    i_null_pointer,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [2:0]              o_status,
    output logic [psa_pkg::OFF_W-1:0]   o_result_offset
);
    import psa_pkg::*;

    localparam int PG_W   = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int PGC_W  = $clog2(PAGES + 1);
    localparam int TDEPTH = PAGES * SEGMENTS;
    localparam int TA_W   = $clog2(TDEPTH);
    localparam int DOFF_W = 20;

    // Reciprocal constants: exact quotient for every input of the given width
    localparam int          NDIV_SH = BYTES_W + $clog2(SEG_BYTES);
    localparam logic [63:0] NDIV_M  =
        ((64'd1 << NDIV_SH) + 64'(SEG_BYTES) - 64'd1) / 64'(SEG_BYTES);
    localparam int          NDIV_PW = BYTES_W + 18;
    localparam int          PDIV_SH = OFF_W + $clog2(PAGE_BYTES);
    localparam logic [63:0] PDIV_M  =
        ((64'd1 << PDIV_SH) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
    localparam int          PDIV_PW = OFF_W + 20;

    // Sequencer states
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_INIT  = 5'd1;
    localparam logic [4:0] S_NEED  = 5'd2;
    localparam logic [4:0] S_PRD   = 5'd3;
    localparam logic [4:0] S_PCHK  = 5'd4;
    localparam logic [4:0] S_SRD   = 5'd5;
    localparam logic [4:0] S_SCHK  = 5'd6;
    localparam logic [4:0] S_TAKE  = 5'd7;
    localparam logic [4:0] S_TAKE2 = 5'd8;
    localparam logic [4:0] S_FB    = 5'd9;
    localparam logic [4:0] S_FCHK  = 5'd10;
    localparam logic [4:0] S_LOC   = 5'd11;
    localparam logic [4:0] S_WRD   = 5'd12;
    localparam logic [4:0] S_WCHK  = 5'd13;
    localparam logic [4:0] S_NXT   = 5'd14;
    localparam logic [4:0] S_WCUR  = 5'd15;
    localparam logic [4:0] S_WPRV  = 5'd16;
    localparam logic [4:0] S_RBASE = 5'd17;
    localparam logic [4:0] S_CBASE = 5'd18;
    localparam logic [4:0] S_EMIT  = 5'd19;
    localparam logic [4:0] S_LOC2  = 5'd20;

    // Control registers
    logic [4:0]         r_state, n_state;
    logic               r_started, n_started;
    logic               r_ov, n_ov;
    logic [TA_W-1:0]    r_clr_addr, n_clr_addr;
    logic [SEGC_W-1:0]  r_clr_seg, n_clr_seg;
    logic [PGC_W-1:0]   r_clr_pg, n_clr_pg;

    // Working registers
    logic [OWNER_W-1:0] r_owner, n_owner;
    logic [BYTES_W-1:0] r_rem, n_rem;
    logic [7:0]         r_need, n_need;
    logic [OFF_W-1:0]   r_rel, n_rel;
    logic [PGC_W-1:0]   r_pg, n_pg;
    logic [TA_W-1:0]    r_base, n_base;
    logic [OFF_W-1:0]   r_pbyte, n_pbyte;
    logic [SEGC_W-1:0]  r_seg, n_seg;
    logic [6:0]         r_len, n_len;
    logic [6:0]         r_new, n_new;
    logic [TA_W-1:0]    r_cur, n_cur;
    logic [TA_W-1:0]    r_prev, n_prev;
    logic               r_prev_avail, n_prev_avail;
    logic [6:0]         r_prev_len, n_prev_len;
    logic               r_have_free, n_have_free;
    logic               r_has_page, n_has_page;
    logic [PG_W-1:0]    r_free_pg, n_free_pg;
    logic [TA_W-1:0]    r_free_base, n_free_base;
    logic [OFF_W-1:0]   r_free_pbyte, n_free_pbyte;
    t_status            r_res_st, n_res_st;
    logic [OFF_W-1:0]   r_res_off, n_res_off;
    t_status            r_out_st, n_out_st;
    logic [OFF_W-1:0]   r_out_off, n_out_off;

    // RAM ports
    logic               pt_rd_en, pt_wr_en;
    logic [PG_W-1:0]    pt_rd_addr, pt_wr_addr;
    logic [PTE_W-1:0]   pt_rd_data, pt_wr_data;
    logic               tg_rd_en, tg_wr_en;
    logic [TA_W-1:0]    tg_rd_addr, tg_wr_addr;
    logic [7:0]         tg_rd_data_raw, tg_wr_data;
    t_tag               tg_q;

    logic               accept;
    logic               out_free;
    logic [DOFF_W-1:0]  seg_doff;
    logic [SEGC_W-1:0]  seg_step;
    logic [OFF_W-1:0]   alloc_off;
    logic [NDIV_PW-1:0] need_prod;
    logic [BYTES_W-1:0] need_q;
    logic [PDIV_PW-1:0] pg_prod;
    logic [OFF_W-1:0]   pg_q;

    psa_ram #(.W(PTE_W), .DEPTH(PAGES), .AW(PG_W)) u_page_ram (
        .i_clk     (i_clk),
        .i_rd_en   (pt_rd_en),
        .i_rd_addr (pt_rd_addr),
        .o_rd_data (pt_rd_data),
        .i_wr_en   (pt_wr_en),
        .i_wr_addr (pt_wr_addr),
        .i_wr_data (pt_wr_data)
    );

    psa_ram #(.W(8), .DEPTH(TDEPTH), .AW(TA_W)) u_tag_ram (
        .i_clk     (i_clk),
        .i_rd_en   (tg_rd_en),
        .i_rd_addr (tg_rd_addr),
        .o_rd_data (tg_rd_data_raw),
        .i_wr_en   (tg_wr_en),
        .i_wr_addr (tg_wr_addr),
        .i_wr_data (tg_wr_data)
    );

    assign tg_q       = t_tag'(tg_rd_data_raw);
    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_ov || !i_out_stall;

    // Data offset of segment r_seg within a page
    assign seg_doff  = DOFF_W'(SEGMENTS) + DOFF_W'(r_seg) * DOFF_W'(SEG_BYTES);
    // Run step, a zero length counts as one
    assign seg_step  = (tg_q.len == 7'd0) ? SEGC_W'(1) : SEGC_W'(tg_q.len);
    assign alloc_off = r_pbyte + seg_doff[OFF_W-1:0];

    // Byte size over segment size, and offset over page size, by reciprocal
    assign need_prod = NDIV_PW'(r_rem) * NDIV_PW'(NDIV_M);
    assign need_q    = BYTES_W'(need_prod >> NDIV_SH);
    assign pg_prod   = PDIV_PW'(r_rel) * PDIV_PW'(PDIV_M);
    assign pg_q      = OFF_W'(pg_prod >> PDIV_SH);

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_started    = r_started;
        n_ov         = r_ov;
        n_clr_addr   = r_clr_addr;
        n_clr_seg    = r_clr_seg;
        n_clr_pg     = r_clr_pg;
        n_owner      = r_owner;
        n_rem        = r_rem;
        n_need       = r_need;
        n_rel        = r_rel;
        n_pg         = r_pg;
        n_base       = r_base;
        n_pbyte      = r_pbyte;
        n_seg        = r_seg;
        n_len        = r_len;
        n_new        = r_new;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_prev_avail = r_prev_avail;
        n_prev_len   = r_prev_len;
        n_have_free  = r_have_free;
        n_has_page   = r_has_page;
        n_free_pg    = r_free_pg;
        n_free_base  = r_free_base;
        n_free_pbyte = r_free_pbyte;
        n_res_st     = r_res_st;
        n_res_off    = r_res_off;
        n_out_st     = r_out_st;
        n_out_off    = r_out_off;
        pt_rd_en     = 1'b0;
        pt_rd_addr   = r_pg[PG_W-1:0];
        pt_wr_en     = 1'b0;
        pt_wr_addr   = r_pg[PG_W-1:0];
        pt_wr_data   = '0;
        tg_rd_en     = 1'b0;
        tg_rd_addr   = r_base + TA_W'(r_seg);
        tg_wr_en     = 1'b0;
        tg_wr_addr   = r_cur;
        tg_wr_data   = '0;

        // Output register drains independently
        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            // Clearing pass: tag 0 of each page free with full length
            S_INIT: begin
                tg_wr_en   = 1'b1;
                tg_wr_addr = r_clr_addr;
                tg_wr_data = (r_clr_seg == '0) ? {1'b0, 7'(SEGMENTS)} : 8'd0;
                if (r_clr_seg == '0) begin
                    pt_wr_en   = 1'b1;
                    pt_wr_addr = r_clr_pg[PG_W-1:0];
                end
                n_clr_addr = r_clr_addr + TA_W'(1);
                if (r_clr_seg == SEGC_W'(SEGMENTS - 1)) begin
                    n_clr_seg = '0;
                    n_clr_pg  = r_clr_pg + PGC_W'(1);
                end else begin
                    n_clr_seg = r_clr_seg + SEGC_W'(1);
                end
                if (r_clr_addr == TA_W'(TDEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end

            // Take a request and branch on its kind
            S_IDLE: begin
                if (accept) begin
                    n_owner = i_owner_id;
                    n_rem   = i_request_bytes;
                    n_rel   = i_free_offset;
                    n_pg    = '0;
                    n_base  = '0;
                    n_pbyte = '0;
                    n_res_off = '0;
                    if (i_kind) begin
                        if (i_null_pointer) begin
                            n_res_st = STAT_NULL_FREE;
                            n_state  = S_EMIT;
                        end else if (!r_started) begin
                            n_res_st = STAT_NOT_ALLOC;
                            n_state  = S_EMIT;
                        end else begin
                            n_state = S_LOC;
                        end
                    end else if (i_request_bytes == '0) begin
                        n_res_st = STAT_ZERO_SIZE;
                        n_state  = S_EMIT;
                    end else begin
                        n_started = 1'b1;
                        n_need    = 8'd1;
                        n_state   = S_NEED;
                    end
                end
            end

            // Segments needed, saturating above the longest run
            S_NEED: begin
                if (need_q >= BYTES_W'(NEED_MAX - 1)) begin
                    n_need = 8'(NEED_MAX);
                end else begin
                    n_need = 8'(need_q) + 8'd1;
                end
                n_have_free = 1'b0;
                n_has_page  = 1'b0;
                n_state     = S_PRD;
            end

            // Page scan: read owner entry
            S_PRD: begin
                if (r_pg == PGC_W'(PAGES)) begin
                    n_state = S_FB;
                end else begin
                    pt_rd_en = 1'b1;
                    n_state  = S_PCHK;
                end
            end

            S_PCHK: begin
                if (!pt_rd_data[PTE_W-1]) begin
                    if (!r_have_free) begin
                        n_have_free  = 1'b1;
                        n_free_pg    = r_pg[PG_W-1:0];
                        n_free_base  = r_base;
                        n_free_pbyte = r_pbyte;
                    end
                    n_pg    = r_pg + PGC_W'(1);
                    n_base  = r_base + TA_W'(SEGMENTS);
                    n_pbyte = r_pbyte + OFF_W'(PAGE_BYTES);
                    n_state = S_PRD;
                end else if (pt_rd_data[OWNER_W-1:0] == r_owner) begin
                    n_has_page = 1'b1;
                    n_seg      = '0;
                    n_state    = S_SRD;
                end else begin
                    n_pg    = r_pg + PGC_W'(1);
                    n_base  = r_base + TA_W'(SEGMENTS);
                    n_pbyte = r_pbyte + OFF_W'(PAGE_BYTES);
                    n_state = S_PRD;
                end
            end

            // Run walk in an owned page, first fit
            S_SRD: begin
                if (r_seg >= SEGC_W'(SEGMENTS)) begin
                    n_pg    = r_pg + PGC_W'(1);
                    n_base  = r_base + TA_W'(SEGMENTS);
                    n_pbyte = r_pbyte + OFF_W'(PAGE_BYTES);
                    n_state = S_PRD;
                end else begin
                    tg_rd_en = 1'b1;
                    n_state  = S_SCHK;
                end
            end

            S_SCHK: begin
                if (!tg_q.used && r_need <= 8'(tg_q.len)) begin
                    n_len   = tg_q.len;
                    n_state = S_TAKE;
                end else begin
                    n_seg   = r_seg + seg_step;
                    n_state = S_SRD;
                end
            end

            // Split off the remainder of the run, if it lies inside the page
            S_TAKE: begin
                if (r_need < 8'(r_len) && (r_seg + r_need) < SEGC_W'(SEGMENTS)) begin
                    tg_wr_en   = 1'b1;
                    tg_wr_addr = r_base + TA_W'(r_seg) + TA_W'(r_need);
                    tg_wr_data = {1'b0, r_len - r_need[6:0]};
                end
                n_state = S_TAKE2;
            end

            S_TAKE2: begin
                tg_wr_en   = 1'b1;
                tg_wr_addr = r_base + TA_W'(r_seg);
                tg_wr_data = {1'b1, r_need[6:0]};
                n_res_st   = STAT_OK;
                n_res_off  = alloc_off;
                n_state    = S_EMIT;
            end

            // No fit: try the first free page, unless the owner already holds a page (owner 0 excepted)
            S_FB: begin
                if (r_have_free && (!r_has_page || r_owner == '0)) begin
                    n_pg       = PGC_W'(r_free_pg);
                    n_base     = r_free_base;
                    n_pbyte    = r_free_pbyte;
                    n_seg      = '0;
                    tg_rd_en   = 1'b1;
                    tg_rd_addr = r_free_base;
                    n_state    = S_FCHK;
                end else begin
                    n_res_st = STAT_NO_MEM;
                    n_state  = S_EMIT;
                end
            end

            S_FCHK: begin
                if (r_need <= 8'(tg_q.len)) begin
                    pt_wr_en   = 1'b1;
                    pt_wr_data = {1'b1, r_owner};
                    n_len      = tg_q.len;
                    n_state    = S_TAKE;
                end else begin
                    n_res_st = STAT_NO_MEM;
                    n_state  = S_EMIT;
                end
            end

            // Free: page index from the offset, reject beyond the last page
            S_LOC: begin
                if (pg_q >= OFF_W'(PAGES)) begin
                    n_res_st = STAT_NOT_ALLOC;
                    n_state  = S_EMIT;
                end else begin
                    n_pg    = PGC_W'(pg_q);
                    n_state = S_LOC2;
                end
            end

            // Free: offset within the page and tag base of the page
            S_LOC2: begin
                n_rel        = r_rel - OFF_W'(r_pg) * OFF_W'(PAGE_BYTES);
                n_base       = TA_W'(r_pg) * TA_W'(SEGMENTS);
                n_seg        = '0;
                n_prev_avail = 1'b0;
                n_state      = S_WRD;
            end

            // Free: walk runs to the one whose data starts at the offset
            S_WRD: begin
                if (r_seg >= SEGC_W'(SEGMENTS)) begin
                    n_res_st = STAT_NOT_ALLOC;
                    n_state  = S_EMIT;
                end else begin
                    tg_rd_en = 1'b1;
                    n_state  = S_WCHK;
                end
            end

            S_WCHK: begin
                if (DOFF_W'(r_rel) == seg_doff) begin
                    if (!tg_q.used) begin
                        n_res_st = STAT_DBL_FREE;
                        n_state  = S_EMIT;
                    end else begin
                        n_len = tg_q.len;
                        n_cur = r_base + TA_W'(r_seg);
                        if ((r_seg + SEGC_W'(tg_q.len)) < SEGC_W'(SEGMENTS)) begin
                            tg_rd_en   = 1'b1;
                            tg_rd_addr = r_base + TA_W'(r_seg) + TA_W'(tg_q.len);
                            n_state    = S_NXT;
                        end else begin
                            n_new   = tg_q.len;
                            n_state = S_WCUR;
                        end
                    end
                end else begin
                    n_prev       = r_base + TA_W'(r_seg);
                    n_prev_avail = !tg_q.used;
                    n_prev_len   = tg_q.len;
                    n_seg        = r_seg + seg_step;
                    n_state      = S_WRD;
                end
            end

            // Merge with a free next run
            S_NXT: begin
                n_new   = tg_q.used ? r_len : (r_len + tg_q.len);
                n_state = S_WCUR;
            end

            S_WCUR: begin
                tg_wr_en   = 1'b1;
                tg_wr_addr = r_cur;
                tg_wr_data = {1'b0, r_new};
                n_state    = r_prev_avail ? S_WPRV : S_RBASE;
            end

            // Merge into a free previous run
            S_WPRV: begin
                tg_wr_en   = 1'b1;
                tg_wr_addr = r_prev;
                tg_wr_data = {1'b0, r_new + r_prev_len};
                n_state    = S_RBASE;
            end

            // Release the page once its first run spans it all
            S_RBASE: begin
                tg_rd_en   = 1'b1;
                tg_rd_addr = r_base;
                n_state    = S_CBASE;
            end

            S_CBASE: begin
                if (!tg_q.used && tg_q.len == 7'(SEGMENTS)) begin
                    pt_wr_en   = 1'b1;
                    pt_wr_data = '0;
                end
                n_res_st = STAT_OK;
                n_state  = S_EMIT;
            end

            // Hand the result to the output register
            S_EMIT: begin
                if (out_free) begin
                    n_ov      = 1'b1;
                    n_out_st  = r_res_st;
                    n_out_off = r_res_off;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_started  <= 1'b0;
            r_ov       <= 1'b0;
            r_clr_addr <= '0;
            r_clr_seg  <= '0;
            r_clr_pg   <= '0;
        end else begin
            r_state    <= n_state;
            r_started  <= n_started;
            r_ov       <= n_ov;
            r_clr_addr <= n_clr_addr;
            r_clr_seg  <= n_clr_seg;
            r_clr_pg   <= n_clr_pg;
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        r_owner      <= n_owner;
        r_rem        <= n_rem;
        r_need       <= n_need;
        r_rel        <= n_rel;
        r_pg         <= n_pg;
        r_base       <= n_base;
        r_pbyte      <= n_pbyte;
        r_seg        <= n_seg;
        r_len        <= n_len;
        r_new        <= n_new;
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_prev_avail <= n_prev_avail;
        r_prev_len   <= n_prev_len;
        r_have_free  <= n_have_free;
        r_has_page   <= n_has_page;
        r_free_pg    <= n_free_pg;
        r_free_base  <= n_free_base;
        r_free_pbyte <= n_free_pbyte;
        r_res_st     <= n_res_st;
        r_res_off    <= n_res_off;
        r_out_st     <= n_out_st;
        r_out_off    <= n_out_off;
    end

    assign o_out_valid     = r_ov;
    assign o_status        = r_out_st;
    assign o_result_offset = r_out_off;

endmodule

// ===== rtl/psa_check.sv =====
// Port-level checker for the paged segment allocator, with its bind.
// Depends on psa_pkg and the top level paged_segment_allocator_core.
module psa_check (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic [2:0]              status,
    input logic [psa_pkg::OFF_W-1:0] offset
);
    import psa_pkg::*;

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // Status codes stay in the defined range
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= STAT_NOT_ALLOC)
        else $error("undefined status");

    // Only a successful request carries an offset
    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STAT_OK |-> offset == '0)
        else $error("offset on failed request");

    // One request at a time: stall follows an accepted request
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken while busy");

    // No result straight out of reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result after reset");

endmodule

bind paged_segment_allocator_core psa_check u_psa_check (
    .clk       (i_clk),
    .rst_n     (i_rst_n),
    .in_valid  (i_in_valid),
    .in_stall  (o_in_stall),
    .out_valid (o_out_valid),
    .out_stall (i_out_stall),
    .status    (o_status),
    .offset    (o_result_offset)
);

// ===== tb/paged_segment_allocator_core_tb.sv =====
// Self-checking testbench for paged_segment_allocator_core.
// Depends on psa_pkg; predicts each response from its own copy of page and tag state.
module paged_segment_allocator_core_tb;
    import psa_pkg::*;

    localparam int NPAGES    = 64;
    localparam int NSEGS     = 124;
    localparam int SEGB      = 32;
    localparam int PAGEB     = 4096;
    localparam int MAX_CYCLES = 100000000;

    localparam bit KIND_ALLOC = 1'b0;
    localparam bit KIND_FREE  = 1'b1;

    typedef struct packed {
        t_status            status;
        logic [OFF_W-1:0]   offset;
    } t_resp;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_kind;
    logic [BYTES_W-1:0] i_request_bytes;
    logic [OWNER_W-1:0] i_owner_id;
    logic [OFF_W-1:0]   i_free_offset;
    logic               i_null_pointer;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [2:0]         o_status;
    logic [OFF_W-1:0]   o_result_offset;

    paged_segment_allocator_core DUT (.*);

    // Predictor state
    logic [PTE_W-1:0] pm_owner [NPAGES];
    t_tag             pm_tags [NPAGES*NSEGS];
    bit               pm_started;
    t_resp            resp_q[$];
    // Offsets of live allocations, used to build well-formed frees
    logic [OFF_W-1:0] live_q[$];

    int  n_errors;
    int  cycle_cnt;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  recv_hold;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int run_len(t_tag t);
        return (t.len == 0) ? 1 : int'(t.len);
    endfunction

    function automatic logic [OFF_W-1:0] seg_offset(int pg, int sg);
        return OFF_W'(pg * PAGEB + NSEGS + sg * SEGB);
    endfunction

    // Split a free run, marking the head used
    function automatic void claim_run(int pg, int sg, int len, int need);
        int base;
        base = pg * NSEGS;
        if (need < len && sg + need < NSEGS)
            pm_tags[base + sg + need] = '{used: 1'b0, len: 7'(len - need)};
        pm_tags[base + sg] = '{used: 1'b1, len: 7'(need)};
    endfunction

    function automatic t_resp predict_alloc(int bytes, logic [OWNER_W-1:0] owner);
        t_resp r;
        int need, sg, len, free_pg, base;
        bit have_free, has_page;
        t_tag t;
        r = '0;
        have_free = 0;
        has_page = 0;
        free_pg = 0;
        if (bytes == 0) begin
            r.status = STAT_ZERO_SIZE;
            return r;
        end
        pm_started = 1;
        need = bytes / SEGB + 1;
        for (int p = 0; p < NPAGES; p++) begin
            if (!pm_owner[p][OWNER_W]) begin
                if (!have_free) begin
                    have_free = 1;
                    free_pg = p;
                end
            end else if (pm_owner[p][OWNER_W-1:0] == owner) begin
                has_page = 1;
                base = p * NSEGS;
                sg = 0;
                while (sg < NSEGS) begin
                    t = pm_tags[base + sg];
                    len = t.len;
                    if (!t.used && need <= len) begin
                        claim_run(p, sg, len, need);
                        r.status = STAT_OK;
                        r.offset = seg_offset(p, sg);
                        return r;
                    end
                    sg += run_len(t);
                end
            end
        end
        if (have_free && (!has_page || owner == 0)) begin
            len = pm_tags[free_pg * NSEGS].len;
            if (need <= len) begin
                pm_owner[free_pg] = {1'b1, owner};
                claim_run(free_pg, 0, len, need);
                r.status = STAT_OK;
                r.offset = seg_offset(free_pg, 0);
                return r;
            end
        end
        r.status = STAT_NO_MEM;
        return r;
    endfunction

    function automatic t_resp predict_free(int off, bit nullp);
        t_resp r;
        int pg, rel, base, sg, len, cur, prev_idx, prev_len;
        bit prev_avail;
        t_tag t;
        r = '0;
        prev_idx = 0;
        prev_len = 0;
        prev_avail = 0;
        if (nullp) begin
            r.status = STAT_NULL_FREE;
            return r;
        end
        if (!pm_started || off / PAGEB >= NPAGES) begin
            r.status = STAT_NOT_ALLOC;
            return r;
        end
        pg = off / PAGEB;
        rel = off - pg * PAGEB;
        base = pg * NSEGS;
        sg = 0;
        while (sg < NSEGS) begin
            cur = base + sg;
            t = pm_tags[cur];
            len = t.len;
            if (rel == NSEGS + sg * SEGB) begin
                if (!t.used) begin
                    r.status = STAT_DBL_FREE;
                    return r;
                end
                pm_tags[cur] = '{used: 1'b0, len: 7'(len)};
                if (sg + len < NSEGS && !pm_tags[cur + len].used)
                    pm_tags[cur].len = 7'(len + pm_tags[cur + len].len);
                if (prev_avail)
                    pm_tags[prev_idx] = '{used: 1'b0, len: 7'(pm_tags[cur].len + prev_len)};
                if (!pm_tags[base].used && pm_tags[base].len == NSEGS)
                    pm_owner[pg][OWNER_W] = 1'b0;
                r.status = STAT_OK;
                return r;
            end
            prev_idx = cur;
            prev_avail = !t.used;
            prev_len = len;
            sg += run_len(t);
        end
        r.status = STAT_NOT_ALLOC;
        return r;
    endfunction

    // Send one request and queue its predicted response
    task automatic send_request(bit kind, int bytes, int owner, int off, bit nullp);
        t_resp r;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_kind          <= kind;
        i_request_bytes <= BYTES_W'(bytes);
        i_owner_id      <= OWNER_W'(owner);
        i_free_offset   <= OFF_W'(off);
        i_null_pointer  <= nullp;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (kind == KIND_FREE) r = predict_free(off, nullp);
        else r = predict_alloc(bytes, OWNER_W'(owner));
        if (kind == KIND_ALLOC && r.status == STAT_OK) live_q.push_back(r.offset);
        resp_q.push_back(r);
    endtask

    task automatic wait_drained();
        while (resp_q.size() != 0) @(posedge i_clk);
        repeat (1000) @(posedge i_clk);
    endtask

    // Response checker
    always @(posedge i_clk) begin
        t_resp e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (resp_q.size() == 0) begin
                $error("response with none pending: status %0d", o_status);
                n_errors++;
            end else begin
                e = resp_q.pop_front();
                if (o_status !== e.status) begin
                    $error("status: expected %0d actual %0d", e.status, o_status);
                    n_errors++;
                end
                if (o_result_offset !== e.offset) begin
                    $error("result_offset: expected %0d actual %0d", e.offset, o_result_offset);
                    n_errors++;
                end
            end
        end
    end

    // Receiver stall
    always @(posedge i_clk) begin
        if (recv_hold) i_out_stall <= 1'b1;
        else i_out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end

    task automatic test_directed();
        send_request(KIND_FREE, 0, 0, NSEGS, 0);         // free before start
        send_request(KIND_FREE, 0, 0, 0, 1);             // null free
        send_request(KIND_ALLOC, 0, 5, 0, 0);            // zero size
        send_request(KIND_FREE, 0, 0, NSEGS, 0);         // still not started
        send_request(KIND_ALLOC, 1, 7, 0, 0);
        send_request(KIND_ALLOC, 31, 7, 0, 0);
        send_request(KIND_ALLOC, 32, 7, 0, 0);
        send_request(KIND_ALLOC, 3935, 9, 0, 0);         // all but one segment of a page
        send_request(KIND_ALLOC, 3968, 9, 0, 0);         // too large
        send_request(KIND_ALLOC, 65535, 65535, 0, 0);    // max size
        send_request(KIND_ALLOC, 3000, 7, 0, 0);         // fits in the owner's page
        send_request(KIND_ALLOC, 100, 0, 0, 0);          // library
        send_request(KIND_ALLOC, 3900, 0, 0, 0);         // library extra page
        send_request(KIND_FREE, 0, 0, NSEGS + SEGB, 0);  // middle run
        send_request(KIND_FREE, 0, 0, NSEGS + SEGB, 0);  // already free
        send_request(KIND_FREE, 0, 0, NSEGS, 0);         // merge with next
        send_request(KIND_FREE, 0, 0, NSEGS + 2*SEGB, 0);// merge with previous
        send_request(KIND_FREE, 0, 0, 60*PAGEB + NSEGS, 0); // free page
        send_request(KIND_FREE, 0, 0, 262143, 0);        // last byte of memory
        send_request(KIND_FREE, 0, 0, 5, 0);             // no matching run
        send_request(KIND_FREE, 0, 65535, 262143, 1);
        i_in_valid <= 1'b0;
        wait_drained();
    endtask

    task automatic random_request();
        int sel, idx;
        sel = $urandom_range(99);
        if (sel < 45) begin
            send_request(KIND_ALLOC, ($urandom_range(9) == 0) ? $urandom() & 16'hffff
                         : $urandom_range(600), $urandom_range(6), 0, 0);
        end else if (sel < 85 && live_q.size() > 0) begin
            idx = $urandom_range(live_q.size() - 1);
            send_request(KIND_FREE, $urandom(), $urandom(), live_q[idx], 0);
            live_q.delete(idx);
        end else begin
            send_request($urandom_range(1), $urandom() & 16'hffff, $urandom() & 16'hffff,
                         $urandom() & 18'h3ffff, $urandom_range(1));
        end
    endtask

    task automatic test_random_phase(int n, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (n) random_request();
    endtask

    // Long receiver hold-off while requests keep coming
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                recv_hold = 1'b1;
                repeat (3000) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            begin
                repeat (20) random_request();
                i_in_valid <= 1'b0;
            end
        join
        wait_drained();
    endtask

    initial begin
        n_errors = 0;
        cycle_cnt = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        recv_hold = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        i_kind = 1'b0;
        i_request_bytes = '0;
        i_owner_id = '0;
        i_free_offset = '0;
        i_null_pointer = 1'b0;
        for (int p = 0; p < NPAGES; p++) pm_owner[p] = '0;
        for (int i = 0; i < NPAGES*NSEGS; i++) pm_tags[i] = '0;
        for (int p = 0; p < NPAGES; p++) pm_tags[p*NSEGS] = '{used: 1'b0, len: 7'(NSEGS)};
        pm_started = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_phase(280, 0, 0);
        test_random_phase(280, 49, 0);
        i_in_valid <= 1'b0;
        wait_drained();
        test_random_phase(280, 0, 49);
        test_backpressure();
        test_random_phase(280, 14, 14);
        i_in_valid <= 1'b0;
        wait_drained();

        if (n_errors == 0 && resp_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
